### design/tkmh_pkg.sv
package tkmh_pkg;

  // Heap geometry and field widths
  localparam int unsigned MaxDepth     = 256;
  localparam int unsigned KeyWidth     = 16;
  localparam int unsigned PayloadWidth = 32;
  localparam int unsigned CfgWidth     = 9;
  localparam int unsigned CountWidth   = 9;
  localparam int unsigned KeepReset    = 256;

  // Internal fill count and level numbering
  localparam int unsigned CntWidth  = $clog2(MaxDepth + 1);
  localparam int unsigned NumLevels = CntWidth;
  localparam int unsigned LvlWidth  = $clog2(NumLevels);

  typedef enum logic {
    FUNC_OFFER = 1'b0,
    FUNC_POP   = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_DISCARDED = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  // Kind of wave that travels down the chain of level cells
  typedef enum logic {
    TOK_INSERT = 1'b0,
    TOK_SIFT   = 1'b1
  } tok_op_e;

  typedef struct packed {
    func_e                   func;
    logic [KeyWidth-1:0]     key_value;
    logic [PayloadWidth-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [KeyWidth-1:0]     out_key;
    logic [PayloadWidth-1:0] out_payload;
    status_e                 status;
    logic [CountWidth-1:0]   count;
  } rsp_t;

  typedef struct packed {
    logic [KeyWidth-1:0]     key;
    logic [PayloadWidth-1:0] payload;
  } item_t;

  // Wave handed from one level to the next.
  // insert: idx is the path node at this level, pos1/dep give the path.
  // sift:   idx is the hole at the level above, cnt bounds the children.
  typedef struct packed {
    logic                valid;
    tok_op_e             op;
    logic                placed;
    logic [CntWidth-1:0] idx;
    logic [CntWidth-1:0] pos1;
    logic [LvlWidth-1:0] dep;
    logic [CntWidth-1:0] cnt;
    item_t               item;
  } tok_t;

  // Write handed up to the level above during a sift
  typedef struct packed {
    logic                valid;
    logic [CntWidth-1:0] idx;
    item_t               item;
  } wb_t;

  // Direct read of one entry (root and last entry before a sift)
  typedef struct packed {
    logic                valid;
    logic [LvlWidth-1:0] lvl;
    logic [CntWidth-1:0] idx;
  } fetch_t;

  // Index of the highest set bit, zero for zero
  function automatic logic [LvlWidth-1:0] floor_log2(input logic [CntWidth-1:0] v);
    logic [LvlWidth-1:0] r;
    r = '0;
    for (int i = 0; i < CntWidth; i++) begin
      if (v[i]) begin
        r = LvlWidth'(i);
      end
    end
    return r;
  endfunction

endpackage

### design/tkmh_cell.sv
module tkmh_cell #(
  parameter int unsigned Level = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tkmh_pkg::fetch_t fetch_i,
  input  tkmh_pkg::tok_t   tok_i,
  output tkmh_pkg::tok_t   tok_o,
  input  tkmh_pkg::wb_t    wb_i,
  output tkmh_pkg::wb_t    wb_o,
  output tkmh_pkg::item_t  rd_a_o,
  output tkmh_pkg::item_t  rd_b_o,
  output logic             done_o
);
  import tkmh_pkg::*;

  // Entries of this heap level
  localparam int unsigned LvlSize   = 2 ** Level;
  localparam int unsigned Room      = MaxDepth + 1 - LvlSize;
  localparam int unsigned Depth     = (LvlSize < Room) ? LvlSize : Room;
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [CntWidth:0]   Base  = (CntWidth + 1)'(LvlSize - 1);
  localparam logic [LvlWidth-1:0] LvlId = LvlWidth'(Level);
  localparam bit IsLast = (Level == NumLevels - 1);

  item_t mem_q [Depth];
  item_t rd_a_q, rd_b_q;
  tok_t  stg_q;

  logic [CntWidth-1:0] addr_a, addr_b;
  logic                own_we;
  logic [CntWidth-1:0] own_idx;
  item_t               own_item;
  logic                wr_en;
  logic [CntWidth-1:0] wr_idx;
  item_t               wr_item;

  logic                ins_leaf, ins_take, nxt_bit, go_l, go_r;
  logic [LvlWidth-1:0] shamt;
  logic [CntWidth-1:0] path_sh;
  logic [CntWidth:0]   pos_l, pos_r;
  logic [KeyWidth-1:0] least_key;
  logic [CntWidth-1:0] child_idx;
  item_t               child_item;

  // Read addresses: direct fetch, sibling pair for a sift, path node for insert
  always_comb begin
    addr_a = tok_i.idx;
    addr_b = tok_i.idx;
    if (fetch_i.valid) begin
      addr_a = '0;
      addr_b = fetch_i.idx;
    end else if (tok_i.op == TOK_SIFT) begin
      addr_a = {tok_i.idx[CntWidth-2:0], 1'b0};
      addr_b = {tok_i.idx[CntWidth-2:0], 1'b1};
    end
  end

  // Level storage, registered reads
  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_q[addr_a[AddrWidth-1:0]];
    rd_b_q <= mem_q[addr_b[AddrWidth-1:0]];
    if (wr_en) begin
      mem_q[wr_idx[AddrWidth-1:0]] <= wr_item;
    end
  end

  // Wave register, lines up with the read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= '0;
    end else begin
      stg_q <= tok_i;
    end
  end

  // Compare stage
  always_comb begin
    tok_o      = stg_q;
    tok_o.valid = 1'b0;
    wb_o       = '0;
    own_we     = 1'b0;
    own_idx    = stg_q.idx;
    own_item   = stg_q.item;
    done_o     = 1'b0;

    // insert: next path bit below this level
    shamt    = stg_q.dep - LvlId - 1'b1;
    path_sh  = stg_q.pos1 >> shamt;
    nxt_bit  = path_sh[0];
    ins_leaf = (stg_q.dep == LvlId);
    ins_take = stg_q.placed || (stg_q.item.key < rd_a_q.key);

    // sift: pick the smaller live child, left wins a tie
    pos_l     = Base + {stg_q.idx, 1'b0};
    pos_r     = pos_l + 1'b1;
    go_l      = (pos_l < {1'b0, stg_q.cnt}) && (rd_a_q.key < stg_q.item.key);
    least_key = go_l ? rd_a_q.key : stg_q.item.key;
    go_r      = (pos_r < {1'b0, stg_q.cnt}) && (rd_b_q.key < least_key);
    if (go_r) begin
      child_idx  = {stg_q.idx[CntWidth-2:0], 1'b1};
      child_item = rd_b_q;
    end else begin
      child_idx  = {stg_q.idx[CntWidth-2:0], 1'b0};
      child_item = rd_a_q;
    end

    if (stg_q.valid) begin
      unique case (stg_q.op)
        TOK_INSERT: begin
          if (ins_leaf) begin
            own_we = 1'b1;
            done_o = 1'b1;
          end else begin
            if (ins_take) begin
              own_we       = 1'b1;
              tok_o.item   = rd_a_q;
              tok_o.placed = 1'b1;
            end
            tok_o.idx   = {stg_q.idx[CntWidth-2:0], nxt_bit};
            tok_o.valid = !IsLast;
          end
        end
        TOK_SIFT: begin
          wb_o.valid = 1'b1;
          wb_o.idx   = stg_q.idx;
          if (!go_l && !go_r) begin
            wb_o.item = stg_q.item;
            done_o    = 1'b1;
          end else begin
            wb_o.item = child_item;
            if (IsLast) begin
              own_we   = 1'b1;
              own_idx  = child_idx;
              own_item = stg_q.item;
              done_o   = 1'b1;
            end else begin
              tok_o.valid = 1'b1;
              tok_o.idx   = child_idx;
            end
          end
        end
      endcase
    end
  end

  // Write port: sift write from below, else own write
  always_comb begin
    wr_en   = wb_i.valid || own_we;
    wr_idx  = wb_i.valid ? wb_i.idx : own_idx;
    wr_item = wb_i.valid ? wb_i.item : own_item;
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

### design/top_k_min_heap.sv
// Bounded min-heap that keeps the K largest keyed items offered to it.
// Command channel: drive req_i and raise start; the transaction is taken on
// a clock edge where start is high and busy is low. func selects offer or pop.
// Result channel: done_o is high for exactly one cycle with rsp_o holding the
// status, the popped item (zero otherwise) and the fill count after the
// transaction. The receiver cannot stall; the result is simply presented.
// Capacity: cfg_we_i writes keep_count (clamped to 1..256) between commands.
// The heap is a chain of level cells, one per tree level, each with its own
// storage. An insert wave walks down the path to the new leaf, one level per
// clock; a sift wave walks down from the root, writing the winner back up.
// An insert goes straight to the level walk; a discard ends once the root is
// fetched and compared; replace and pop fetch an entry, then run the sift
// walk; pop on empty answers from idle. busy drops in the cycle done_o is
// high, so the next command may be taken there; the walk sets the throughput.
// Reset empties the heap and sets keep_count to 256; entry storage is not
// cleared, only entries below the fill count are ever read.
module top_k_min_heap (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  tkmh_pkg::req_t                  req_i,
  output logic                            done_o,
  output tkmh_pkg::rsp_t                  rsp_o,
  input  logic                            cfg_we_i,
  input  logic [tkmh_pkg::CfgWidth-1:0]   cfg_wdata_i
);
  import tkmh_pkg::*;

  localparam int unsigned CmpWidth = (CntWidth > CfgWidth) ? CntWidth : CfgWidth;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_CHECK,
    S_WAIT
  } state_e;

  state_e              state_q;
  func_e               op_q;
  item_t               item_q;
  item_t               out_item_q;
  status_e             status_q;
  logic [CntWidth-1:0] count_q;
  logic [LvlWidth-1:0] lvl_q;
  logic [CfgWidth-1:0] keep_q;
  fetch_t              fetch_q;
  tok_t                ins_tok_q, sift_tok_q;
  logic                done_q;
  rsp_t                rsp_q;

  logic [CmpWidth-1:0] keep_ext, cap, cnt_ext;
  logic                has_room;
  item_t               new_item, root_item, last_item;
  tok_t                ins_tok, sift_tok;
  fetch_t              root_fetch, last_fetch;

  tok_t                tok_in  [NumLevels];
  tok_t                tok_out [NumLevels];
  wb_t                 wb_in   [NumLevels];
  wb_t                 wb_up   [NumLevels];
  item_t               rd_a    [NumLevels];
  item_t               rd_b    [NumLevels];
  logic [NumLevels-1:0] cell_done;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= CfgWidth'(KeepReset);
    end else if (cfg_we_i) begin
      keep_q <= cfg_wdata_i;
    end
  end

  // Clamp capacity and check for room
  always_comb begin
    keep_ext = CmpWidth'(keep_q);
    cnt_ext  = CmpWidth'(count_q);
    priority if (keep_ext == '0) begin
      cap = CmpWidth'(1);
    end else if (keep_ext > CmpWidth'(MaxDepth)) begin
      cap = CmpWidth'(MaxDepth);
    end else begin
      cap = keep_ext;
    end
    has_room = cnt_ext < cap;
  end

  // Wave and fetch requests built from the current command
  always_comb begin
    new_item.key     = req_i.key_value;
    new_item.payload = req_i.payload;

    ins_tok       = '0;
    ins_tok.valid = 1'b1;
    ins_tok.op    = TOK_INSERT;
    ins_tok.pos1  = count_q + 1'b1;
    ins_tok.dep   = floor_log2(ins_tok.pos1);
    ins_tok.item  = new_item;

    root_fetch       = '0;
    root_fetch.valid = 1'b1;

    last_fetch       = '0;
    last_fetch.valid = 1'b1;
    last_fetch.lvl   = floor_log2(count_q);
    last_fetch.idx   = count_q ^ (CntWidth'(1) << last_fetch.lvl);

    sift_tok       = '0;
    sift_tok.valid = 1'b1;
    sift_tok.op    = TOK_SIFT;
    sift_tok.cnt   = count_q;
    sift_tok.item  = (op_q == FUNC_POP) ? last_item : item_q;
  end

  // Root comes from level 0, the last entry from the level it sits on
  always_comb begin
    root_item = rd_a[0];
    last_item = rd_b[0];
    for (int l = 0; l < NumLevels; l++) begin
      if (lvl_q == LvlWidth'(l)) begin
        last_item = rd_b[l];
      end
    end
  end

  // Command sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= FUNC_OFFER;
      item_q     <= '0;
      out_item_q <= '0;
      status_q   <= ST_INSERTED;
      count_q    <= '0;
      lvl_q      <= '0;
      fetch_q    <= '0;
      ins_tok_q  <= '0;
      sift_tok_q <= '0;
      done_q     <= 1'b0;
      rsp_q      <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          // only a pop on empty answers straight from idle
          done_q <= start && (req_i.func == FUNC_POP) && (count_q == '0);
          if (start) begin
            op_q       <= req_i.func;
            item_q     <= new_item;
            out_item_q <= '0;
            if (req_i.func == FUNC_OFFER) begin
              if (has_room) begin
                ins_tok_q <= ins_tok;
                status_q  <= ST_INSERTED;
                count_q   <= count_q + 1'b1;
                state_q   <= S_WAIT;
              end else begin
                fetch_q <= root_fetch;
                state_q <= S_FETCH;
              end
            end else if (count_q == '0) begin
              rsp_q.out_key     <= '0;
              rsp_q.out_payload <= '0;
              rsp_q.status      <= ST_EMPTY;
              rsp_q.count       <= '0;
            end else begin
              fetch_q <= last_fetch;
              lvl_q   <= last_fetch.lvl;
              count_q <= count_q - 1'b1;
              state_q <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          fetch_q.valid <= 1'b0;
          state_q       <= S_CHECK;
        end
        S_CHECK: begin
          if (op_q == FUNC_OFFER) begin
            if (item_q.key > root_item.key) begin
              sift_tok_q <= sift_tok;
              status_q   <= ST_REPLACED;
              state_q    <= S_WAIT;
            end else begin
              done_q            <= 1'b1;
              rsp_q.out_key     <= '0;
              rsp_q.out_payload <= '0;
              rsp_q.status      <= ST_DISCARDED;
              rsp_q.count       <= CountWidth'(count_q);
              state_q           <= S_IDLE;
            end
          end else begin
            out_item_q <= root_item;
            sift_tok_q <= sift_tok;
            status_q   <= ST_POPPED;
            state_q    <= S_WAIT;
          end
        end
        S_WAIT: begin
          // wave requests last one cycle
          ins_tok_q.valid  <= 1'b0;
          sift_tok_q.valid <= 1'b0;
          if (|cell_done) begin
            done_q            <= 1'b1;
            rsp_q.out_key     <= out_item_q.key;
            rsp_q.out_payload <= out_item_q.payload;
            rsp_q.status      <= status_q;
            rsp_q.count       <= CountWidth'(count_q);
            state_q           <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Chain of level cells
  for (genvar l = 0; l < NumLevels; l++) begin : g_cell
    if (l == 0) begin : g_head
      assign tok_in[l] = ins_tok_q;
    end else if (l == 1) begin : g_sift_entry
      assign tok_in[l] = sift_tok_q.valid ? sift_tok_q : tok_out[0];
    end else begin : g_link
      assign tok_in[l] = tok_out[l-1];
    end

    if (l == NumLevels - 1) begin : g_tail
      assign wb_in[l] = '0;
    end else begin : g_wb_link
      assign wb_in[l] = wb_up[l+1];
    end

    tkmh_cell #(
      .Level(l)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .fetch_i(fetch_q),
      .tok_i  (tok_in[l]),
      .tok_o  (tok_out[l]),
      .wb_i   (wb_in[l]),
      .wb_o   (wb_up[l]),
      .rd_a_o (rd_a[l]),
      .rd_b_o (rd_b[l]),
      .done_o (cell_done[l])
    );
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
